// ===== sv/pfde_pkg.sv =====
package pfde_pkg;

   // Default geometry of the panel.
   localparam int DEF_WIDTH      = 70;
   localparam int DEF_HEIGHT     = 48;
   localparam int DEF_ROW_STRIDE = 128;

   localparam int ADDR_W = 10;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Bit 3 of the icon register has no icon behind it and always reads zero.
   localparam logic [7:0] ICON_MASK = 8'hF7;
   localparam int ICON_PLUG_BIT    = 0;
   localparam int ICON_DROP_BIT    = 1;
   localparam int ICON_FRAME_BIT   = 2;

   typedef enum logic [2:0] {
      KIND_PIXEL       = 3'd0,
      KIND_REFRESH     = 3'd1,
      KIND_ICON_UPDATE = 3'd2,
      KIND_ICON_DIRECT = 3'd3,
      KIND_BARS        = 3'd4,
      KIND_FILL        = 3'd5
   } kind_type;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_TOGGLE = 2'd2;

   localparam logic [1:0] REG_BATTERY_FRAME = 2'd0;
   localparam logic [1:0] REG_BATTERY_BARS  = 2'd1;
   localparam logic [1:0] REG_SIGNAL_BARS   = 2'd2;

   typedef enum logic [2:0] {
      RES_SCAN,
      RES_FRAME,
      RES_ICON_BARS,
      RES_SIGNAL,
      RES_FILL
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        rd_pixel;
      logic        icon_load;
      logic        icon_direct;
      logic        pix_write;
      logic        sweep;
      logic        sweep_zero;
      logic        emit;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic sweep_last;
   } status_type;

endpackage

// ===== sv/pfde_csr.sv =====
module pfde_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pfde_pkg::CSR_AW-1:0]   paddr,
   input  logic [pfde_pkg::CSR_DW-1:0]   pwdata,
   output logic [pfde_pkg::CSR_DW-1:0]   prdata,
   output logic [pfde_pkg::ADDR_W-1:0]   battery_frame_address,
   output logic [pfde_pkg::ADDR_W-1:0]   battery_bars_address,
   output logic [pfde_pkg::ADDR_W-1:0]   signal_bars_address
);
   import pfde_pkg::*;

   logic [ADDR_W-1:0] frame_addr_ff;
   logic [ADDR_W-1:0] bars_addr_ff;
   logic [ADDR_W-1:0] signal_addr_ff;
   logic              wr_en;
   logic [1:0]        reg_index;

   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_addr_ff  <= '0;
         bars_addr_ff   <= '0;
         signal_addr_ff <= '0;
      end else if (wr_en) begin
         case (reg_index)
            REG_BATTERY_FRAME: frame_addr_ff  <= pwdata[ADDR_W-1:0];
            REG_BATTERY_BARS:  bars_addr_ff   <= pwdata[ADDR_W-1:0];
            REG_SIGNAL_BARS:   signal_addr_ff <= pwdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_BATTERY_FRAME: prdata = CSR_DW'(frame_addr_ff);
         REG_BATTERY_BARS:  prdata = CSR_DW'(bars_addr_ff);
         REG_SIGNAL_BARS:   prdata = CSR_DW'(signal_addr_ff);
         default:           prdata = '0;
      endcase
   end

   assign battery_frame_address = frame_addr_ff;
   assign battery_bars_address  = bars_addr_ff;
   assign signal_bars_address   = signal_addr_ff;

endmodule

// ===== sv/pfde_ctrl.sv =====
module pfde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_kind,
   input  pfde_pkg::status_type  status,
   output pfde_pkg::cmd_type     cmd
);
   import pfde_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_PIXEL  = 6'b000100,
      ST_FILL   = 6'b001000,
      ST_EMIT_A = 6'b010000,
      ST_EMIT_B = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   kind_type  req_kind_t;
   logic      accept;

   assign req_kind_t = kind_type'(req_kind);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      cmd             = '0;
      cmd.res_sel     = RES_SCAN;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load        = 1'b1;
               cmd.rd_pixel    = (req_kind_t == KIND_PIXEL);
               cmd.icon_load   = (req_kind_t == KIND_ICON_UPDATE) ||
                                 (req_kind_t == KIND_ICON_DIRECT);
               cmd.icon_direct = (req_kind_t == KIND_ICON_DIRECT);
               kind_in         = req_kind_t;
               case (req_kind_t)
                  KIND_PIXEL:       state_in = ST_PIXEL;
                  KIND_FILL:        state_in = ST_FILL;
                  KIND_REFRESH,
                  KIND_ICON_UPDATE,
                  KIND_ICON_DIRECT,
                  KIND_BARS:        state_in = ST_EMIT_A;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIXEL: begin
            cmd.pix_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FILL: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            case (kind_ff)
               KIND_REFRESH:     cmd.res_sel = RES_SCAN;
               KIND_ICON_UPDATE,
               KIND_ICON_DIRECT: cmd.res_sel = RES_FRAME;
               KIND_BARS:        cmd.res_sel = RES_SIGNAL;
               default:          cmd.res_sel = RES_FILL;
            endcase
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if ((kind_ff == KIND_ICON_UPDATE) || (kind_ff == KIND_ICON_DIRECT)) begin
                  state_in = ST_EMIT_B;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_B: begin
            cmd.res_sel = RES_ICON_BARS;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= KIND_PIXEL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== sv/pfde_dpath.sv =====
module pfde_dpath #(
   parameter int WIDTH      = pfde_pkg::DEF_WIDTH,
   parameter int HEIGHT     = pfde_pkg::DEF_HEIGHT,
   parameter int ROW_STRIDE = pfde_pkg::DEF_ROW_STRIDE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pfde_pkg::cmd_type            cmd,
   output pfde_pkg::status_type         status,
   input  logic [7:0]                   req_pixel_x,
   input  logic [7:0]                   req_pixel_y,
   input  logic [1:0]                   req_pixel_mode,
   input  logic [7:0]                   req_value,
   input  logic                         req_turn_on,
   input  logic [pfde_pkg::ADDR_W-1:0]  battery_frame_address,
   input  logic [pfde_pkg::ADDR_W-1:0]  battery_bars_address,
   input  logic [pfde_pkg::ADDR_W-1:0]  signal_bars_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_write_valid,
   output logic [pfde_pkg::ADDR_W-1:0]  rsp_write_address,
   output logic [7:0]                   rsp_write_data,
   output logic                         rsp_plug_segment,
   output logic                         rsp_drop_segment,
   output logic                         rsp_clear_pulse,
   output logic                         rsp_last
);
   import pfde_pkg::*;

   localparam int PAGES     = (HEIGHT + 7) / 8;
   localparam int BUF_BYTES = WIDTH * PAGES;
   localparam int IDX_W     = $clog2(BUF_BYTES);
   localparam int COL_W     = $clog2(WIDTH);
   localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;

   logic [7:0]        mem [BUF_BYTES];
   logic [7:0]        rd_data_ff;

   logic [IDX_W-1:0]  sweep_cnt_ff;
   logic [IDX_W-1:0]  scan_ptr_ff;
   logic [COL_W-1:0]  scan_col_ff;
   logic [PAGE_W-1:0] scan_page_ff;
   logic [7:0]        icon_ff;

   logic [IDX_W-1:0]  pix_idx_ff;
   logic [7:0]        mask_ff;
   logic [1:0]        mode_ff;
   logic [7:0]        value_ff;

   logic              out_valid_ff;
   logic              out_wv_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [7:0]        out_data_ff;
   logic              out_plug_ff;
   logic              out_drop_ff;
   logic              out_clr_ff;
   logic              out_last_ff;

   logic [7:0]        px_clamp;
   logic [7:0]        py_clamp;
   logic [PAGE_W-1:0] pix_page;
   logic [10:0]       pix_idx_wide;
   logic [IDX_W-1:0]  pix_idx_in;
   logic [IDX_W-1:0]  rd_addr;
   logic [7:0]        pix_byte;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [7:0]        wr_data;
   logic              sweep_last;
   logic              scan_last;
   logic [11:0]       scan_addr_wide;
   logic [7:0]        icon_base;

   // Pixel coordinates are clamped to the panel before they pick a byte.
   assign px_clamp     = (req_pixel_x >= 8'(WIDTH))  ? 8'(WIDTH - 1)  : req_pixel_x;
   assign py_clamp     = (req_pixel_y >= 8'(HEIGHT)) ? 8'(HEIGHT - 1) : req_pixel_y;
   assign pix_page     = py_clamp[3 +: PAGE_W];
   assign pix_idx_wide = 11'(px_clamp) + 11'(pix_page) * 11'(WIDTH);
   assign pix_idx_in   = pix_idx_wide[IDX_W-1:0];
   assign rd_addr      = cmd.rd_pixel ? pix_idx_in : scan_ptr_ff;

   always_comb begin
      case (mode_ff)
         MODE_CLEAR:  pix_byte = rd_data_ff & ~mask_ff;
         MODE_SET:    pix_byte = rd_data_ff | mask_ff;
         MODE_TOGGLE: pix_byte = rd_data_ff ^ mask_ff;
         default:     pix_byte = rd_data_ff;
      endcase
   end

   assign sweep_last = (sweep_cnt_ff == IDX_W'(BUF_BYTES - 1));
   assign wr_en      = cmd.sweep | cmd.pix_write;
   assign wr_addr    = cmd.sweep ? sweep_cnt_ff : pix_idx_ff;
   assign wr_data    = cmd.sweep ? (cmd.sweep_zero ? 8'h00 : value_ff) : pix_byte;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      if (cmd.icon_direct) begin
         icon_base = req_value;
      end else if (req_turn_on) begin
         icon_base = icon_ff | req_value;
      end else begin
         icon_base = icon_ff & ~req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_idx_ff <= pix_idx_in;
         mask_ff    <= 8'h01 << py_clamp[2:0];
         mode_ff    <= req_pixel_mode;
         value_ff   <= req_value;
      end
   end

   assign scan_last      = (scan_ptr_ff == IDX_W'(BUF_BYTES - 1));
   assign scan_addr_wide = 12'(scan_page_ff) * 12'(ROW_STRIDE) + 12'(scan_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         scan_ptr_ff  <= '0;
         scan_col_ff  <= '0;
         scan_page_ff <= '0;
         icon_ff      <= '0;
      end else begin
         if (cmd.sweep) begin
            sweep_cnt_ff <= sweep_last ? '0 : sweep_cnt_ff + 1'b1;
         end
         if (cmd.icon_load) begin
            icon_ff <= icon_base & ICON_MASK;
         end
         if (cmd.emit && (cmd.res_sel == RES_SCAN)) begin
            if (scan_last) begin
               scan_ptr_ff  <= '0;
               scan_col_ff  <= '0;
               scan_page_ff <= '0;
            end else begin
               scan_ptr_ff <= scan_ptr_ff + 1'b1;
               if (scan_col_ff == COL_W'(WIDTH - 1)) begin
                  scan_col_ff  <= '0;
                  scan_page_ff <= scan_page_ff + 1'b1;
               end else begin
                  scan_col_ff <= scan_col_ff + 1'b1;
               end
            end
         end
      end
   end

   // Output register: a result may wait here while the next item comes in.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_plug_ff <= icon_ff[ICON_PLUG_BIT];
         out_drop_ff <= icon_ff[ICON_DROP_BIT];
         case (cmd.res_sel)
            RES_SCAN: begin
               out_wv_ff   <= 1'b1;
               out_addr_ff <= scan_addr_wide[ADDR_W-1:0];
               out_data_ff <= rd_data_ff;
               out_clr_ff  <= 1'b0;
               out_last_ff <= scan_last;
            end
            RES_FRAME: begin
               out_wv_ff   <= 1'b1;
               out_addr_ff <= battery_frame_address;
               out_data_ff <= {7'd0, icon_ff[ICON_FRAME_BIT]};
               out_clr_ff  <= 1'b0;
               out_last_ff <= 1'b0;
            end
            RES_ICON_BARS: begin
               out_wv_ff   <= 1'b1;
               out_addr_ff <= battery_bars_address;
               out_data_ff <= {4'd0, icon_ff[7:4]};
               out_clr_ff  <= 1'b0;
               out_last_ff <= 1'b1;
            end
            RES_SIGNAL: begin
               out_wv_ff   <= 1'b1;
               out_addr_ff <= signal_bars_address;
               out_data_ff <= value_ff;
               out_clr_ff  <= 1'b0;
               out_last_ff <= 1'b1;
            end
            default: begin
               out_wv_ff   <= 1'b0;
               out_addr_ff <= '0;
               out_data_ff <= '0;
               out_clr_ff  <= (value_ff == 8'h00);
               out_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign status.out_free   = ~out_valid_ff | rsp_ready;
   assign status.sweep_last = sweep_last;

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_valid   = out_wv_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_write_data    = out_data_ff;
   assign rsp_plug_segment  = out_plug_ff;
   assign rsp_drop_segment  = out_drop_ff;
   assign rsp_clear_pulse   = out_clr_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== sv/page_framebuffer_display_engine_unit.sv =====
// Channel   Ports        Contents
// --------  -----------  -----------------------------------------------------
// command   req_t*       tuser kind; tdata pixel_x, pixel_y, pixel_mode, value,
//                        turn_on
// result    rsp_t*       tuser write_valid; tdata write_address, write_data,
//                        plug/drop/clear; tlast last
// control   csr_*        three display address registers at 0x0, 0x4, 0x8
//
// Icon commands make two writes; bars and refresh make one each.
// Pixel set is a read then a write through the framebuffer RAM.
// Fill walks all WIDTH*pages bytes of the RAM one byte a cycle.
// After reset a clearing pass zeroes all WIDTH*pages bytes of the RAM while
// req_tready stays low; register writes are taken during it.
// A result waits in the output register, so a new item is taken while it stalls.
module page_framebuffer_display_engine_unit #(
   parameter int WIDTH      = pfde_pkg::DEF_WIDTH,
   parameter int HEIGHT     = pfde_pkg::DEF_HEIGHT,
   parameter int ROW_STRIDE = pfde_pkg::DEF_ROW_STRIDE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // pixel_x[7:0], pixel_y[15:8], pixel_mode[17:16], value[25:18], turn_on[26]
   input  logic [31:0]                  req_tdata,
   // kind[2:0]
   input  logic [2:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // write_address[9:0], write_data[17:10], plug_segment[18], drop_segment[19],
   // clear_pulse[20]
   output logic [23:0]                  rsp_tdata,
   // write_valid[0]
   output logic                         rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pfde_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [pfde_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [pfde_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import pfde_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] frame_addr;
   logic [ADDR_W-1:0] bars_addr;
   logic [ADDR_W-1:0] signal_addr;
   logic [ADDR_W-1:0] out_addr;
   logic [7:0]        out_data;
   logic              out_plug;
   logic              out_drop;
   logic              out_clr;

   assign csr_pready = 1'b1;

   pfde_csr u_csr (
      .clock                 (clock),
      .reset                 (reset),
      .psel                  (csr_psel),
      .penable               (csr_penable),
      .pwrite                (csr_pwrite),
      .paddr                 (csr_paddr),
      .pwdata                (csr_pwdata),
      .prdata                (csr_prdata),
      .battery_frame_address (frame_addr),
      .battery_bars_address  (bars_addr),
      .signal_bars_address   (signal_addr)
   );

   pfde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pfde_dpath #(
      .WIDTH      (WIDTH),
      .HEIGHT     (HEIGHT),
      .ROW_STRIDE (ROW_STRIDE)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_pixel_x           (req_tdata[7:0]),
      .req_pixel_y           (req_tdata[15:8]),
      .req_pixel_mode        (req_tdata[17:16]),
      .req_value             (req_tdata[25:18]),
      .req_turn_on           (req_tdata[26]),
      .battery_frame_address (frame_addr),
      .battery_bars_address  (bars_addr),
      .signal_bars_address   (signal_addr),
      .rsp_valid             (rsp_tvalid),
      .rsp_ready             (rsp_tready),
      .rsp_write_valid       (rsp_tuser),
      .rsp_write_address     (out_addr),
      .rsp_write_data        (out_data),
      .rsp_plug_segment      (out_plug),
      .rsp_drop_segment      (out_drop),
      .rsp_clear_pulse       (out_clr),
      .rsp_last              (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, out_clr, out_drop, out_plug, out_data, out_addr};

endmodule
